### rtl/text_console_writer_macros.svh
// ---------------------------------------------------------------------------
// text_console_writer_macros.svh
// assertion macros shared by the console rtl
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// shared constants, types and helpers of the text console writer
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int PADDR_W     = 3;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic REG_IDX_FILL_ATTR = 1'b0;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic accept;
    logic sweep_fill;
    logic sweep_copy;
    logic sweep_init;
    logic out_load_now;
    logic out_load_done;
  } tcw_cmd_t;

  typedef struct packed {
    logic scroll_req;
    logic sweep_last;
  } tcw_sts_t;

  function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
    make_cell = {attr, ch};
  endfunction

endpackage

`default_nettype wire

### rtl/tcw_dp.sv
// ---------------------------------------------------------------------------
// tcw_dp
// screen memory, cursor, sweep counter, config register and result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_macros.svh"

module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tcw_cmd_t           cmd,
  output tcw_sts_t                sts,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [7:0]         in_attribute,
  input  wire logic [4:0]         in_read_row,
  input  wire logic [6:0]         in_read_col,
  output logic [4:0]              out_cursor_row,
  output logic [6:0]              out_cursor_col,
  output logic [7:0]              out_cell_char,
  output logic [7:0]              out_cell_attr,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int LIM   = (ROWS - 1) * COLUMNS;

  logic [15:0]   mem [CELLS];

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] idx_r;
  logic [7:0]    fill_attr_r;
  logic [7:0]    scroll_attr_r;
  logic          cell_sel_r;
  logic [15:0]   rdata_r;
  logic          stg_valid_r;
  logic          stg_fill_r;
  logic [AW-1:0] stg_addr_r;
  logic [4:0]    out_row_r;
  logic [6:0]    out_col_r;
  logic [7:0]    out_char_r;
  logic [7:0]    out_attr_r;

  opcode_t       op;
  logic          is_nl;
  logic          last_row;
  logic          last_col;
  logic          line_end;
  logic          put_we;
  logic [AW-1:0] put_addr;
  logic          rd_in_range;
  logic [AW-1:0] rd_addr_in;
  logic          copy_part;
  logic          sweeping;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          cfg_wr;
  logic          cfg_sel;
  logic [31:0]   row_nxt_w;
  logic [31:0]   col_nxt_w;
  logic [31:0]   row_w;
  logic [31:0]   col_w;

  assign op          = opcode_t'(in_opcode);
  assign is_nl       = (in_char_code == NEWLINE_CHAR);
  assign last_row    = (row_r == RW'(ROWS - 1));
  assign last_col    = (col_r == CW'(COLUMNS - 1));
  assign line_end    = is_nl || last_col;
  assign put_we      = cmd.accept && (op == OP_PUT) && !is_nl;
  assign put_addr    = AW'(int'(row_r) * COLUMNS + int'(col_r));
  assign rd_in_range = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS);
  assign rd_addr_in  = AW'(int'(in_read_row) * COLUMNS + int'(in_read_col));
  assign copy_part   = (int'(idx_r) < LIM);
  assign sweeping    = cmd.sweep_fill || cmd.sweep_copy;

  assign sts.scroll_req = (op == OP_PUT) && line_end && last_row;
  assign sts.sweep_last = (idx_r == AW'(CELLS - 1));

  // cursor advance
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    case (op)
      OP_PUT: begin
        if (line_end) begin
          col_nxt = '0;
          if (!last_row) begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      OP_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // single write port: scroll stage, fill sweep, put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = make_cell(BLANK_CHAR, fill_attr_r);
    if (stg_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = stg_addr_r;
      mem_wdata = stg_fill_r ? make_cell(BLANK_CHAR, scroll_attr_r) : rdata_r;
    end else if (cmd.sweep_fill) begin
      mem_we    = 1'b1;
      mem_waddr = idx_r;
      mem_wdata = make_cell(BLANK_CHAR, cmd.sweep_init ? RESET_ATTR : fill_attr_r);
    end else if (put_we) begin
      mem_we    = 1'b1;
      mem_waddr = put_addr;
      mem_wdata = make_cell(in_char_code, in_attribute);
    end
  end

  assign mem_re    = (cmd.accept && (op == OP_READ) && rd_in_range) ||
                     (cmd.sweep_copy && copy_part);
  assign mem_raddr = cmd.sweep_copy ? AW'(int'(idx_r) + COLUMNS) : rd_addr_in;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r         <= '0;
      col_r         <= '0;
      idx_r         <= '0;
      stg_valid_r   <= 1'b0;
      scroll_attr_r <= RESET_ATTR;
    end else begin
      if (cmd.accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      idx_r       <= sweeping ? idx_r + 1'b1 : '0;
      stg_valid_r <= cmd.sweep_copy;
      if (cfg_wr) begin
        scroll_attr_r <= pwdata[7:0];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    stg_addr_r <= idx_r;
    stg_fill_r <= !copy_part;
    if (cmd.accept) begin
      fill_attr_r <= in_attribute;
      cell_sel_r  <= (op == OP_READ) && rd_in_range;
    end
    if (cmd.out_load_now) begin
      out_row_r  <= row_nxt_w[4:0];
      out_col_r  <= col_nxt_w[6:0];
      out_char_r <= '0;
      out_attr_r <= '0;
    end else if (cmd.out_load_done) begin
      out_row_r  <= row_w[4:0];
      out_col_r  <= col_w[6:0];
      out_char_r <= cell_sel_r ? rdata_r[7:0] : 8'h00;
      out_attr_r <= cell_sel_r ? rdata_r[15:8] : 8'h00;
    end
  end

  assign row_nxt_w = 32'(row_nxt);
  assign col_nxt_w = 32'(col_nxt);
  assign row_w     = 32'(row_r);
  assign col_w     = 32'(col_r);

  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

  // config port
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1] == REG_IDX_FILL_ATTR);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
  assign prdata  = cfg_sel ? {24'h000000, scroll_attr_r} : 32'h00000000;

  `TCW_ASSERT(a_cursor_on_screen, (int'(row_r) < ROWS) && (int'(col_r) < COLUMNS))
  `TCW_ASSERT(a_stage_no_put_clash, stg_valid_r |-> !put_we)
  `TCW_ASSERT(a_copy_feeds_stage, cmd.sweep_copy |=> stg_valid_r)

endmodule

`default_nettype wire

### rtl/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// controller: reset clearing pass, item dispatch, sweeps and result hand-off
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_macros.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire tcw_sts_t   sts,
  output tcw_cmd_t        cmd
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_FILL   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_fill = 1'b1;
        cmd.sweep_init = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          case (opcode_t'(in_opcode))
            OP_CLEAR: state_nxt = ST_FILL;
            OP_READ:  state_nxt = ST_DONE;
            OP_PUT: begin
              if (sts.scroll_req) begin
                state_nxt = ST_SCROLL;
              end else begin
                cmd.out_load_now = 1'b1;
              end
            end
            default: cmd.out_load_now = 1'b1;
          endcase
        end
      end
      ST_FILL: begin
        cmd.sweep_fill = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.sweep_copy = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load_done = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load_now || cmd.out_load_done) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TCW_ASSERT(a_load_into_free_slot,
    (cmd.out_load_now || cmd.out_load_done) |-> (!out_valid_r || !out_stall))
  `TCW_ASSERT(a_scroll_ends_in_done,
    (state_r == ST_SCROLL && sts.sweep_last) |=> state_r == ST_DONE)
  `TCW_ASSERT(a_clear_starts_fill, (cmd.accept && in_opcode == OP_CLEAR) |=> state_r == ST_FILL)

endmodule

`default_nettype wire

### rtl/text_console_writer.sv
// put, newline, unused opcode: registered result, one item per cycle unless stalled
// read: registered screen memory read, then the result register loads in ST_DONE
// clear: fill sweep then ST_DONE, one cell write per cycle on the single write port
// scroll: copy sweep then ST_DONE, row copy pipelined through the memory read register
// reset: clearing pass to space/0x0F, input stalled meanwhile
// ---------------------------------------------------------------------------
// text_console_writer
// text-mode console with cursor, wrap, scroll, clear and cell read
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [7:0]         in_attribute,
  input  wire logic [4:0]         in_read_row,
  input  wire logic [6:0]         in_read_col,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_cursor_row,
  output logic [6:0]              out_cursor_col,
  output logic [7:0]              out_cell_char,
  output logic [7:0]              out_cell_attr,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_attribute   (in_attribute),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: text console writer
// Drives put, newline, clear, read and unused-opcode items into the console,
// with random gaps on the input and random stalls on the output. A local
// model of the screen and cursor predicts every result that the directed
// table does not give, and every result is compared with the oldest
// prediction. The scroll fill attribute is rewritten between phases, and one
// long output hold backs the block up into its input.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS        = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CELLS       = ROWS * COLS;
  localparam int SETTLE      = CELLS + 100;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] ch;
    logic [7:0] attr;
    logic [4:0] rr;
    logic [6:0] rc;
  } cmd_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] cchar;
    logic [7:0] cattr;
  } view_t;

  typedef struct {
    cmd_t  cmd;
    int    reps;
    bit    typed;
    view_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_opcode;
  logic [7:0]          in_char_code;
  logic [7:0]          in_attribute;
  logic [4:0]          in_read_row;
  logic [6:0]          in_read_col;
  logic                out_valid;
  logic                out_stall;
  logic [4:0]          out_cursor_row;
  logic [6:0]          out_cursor_col;
  logic [7:0]          out_cell_char;
  logic [7:0]          out_cell_attr;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // screen and cursor as the block should hold them
  logic [15:0] screen [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  fill_attr;

  view_t due_results [$];
  int          errors;
  int          items_sent;
  int          results_seen;
  int          scrolls;
  int          clears;
  bit          hold_req;
  bit          quiet;

  // read after reset, out of range reads, unused opcode, wrap, newline, scroll, clear
  dir_row_t dir_tab [27] = '{
    '{'{OP_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{5'd0, 7'd0, BLANK_CHAR, RESET_ATTR}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd24, 7'd79}, 1, 1'b1,
      '{5'd0, 7'd0, BLANK_CHAR, RESET_ATTR}},
    '{'{OP_READ, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd24, 7'd80}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd25, 7'd0}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_NOP, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_PUT, 8'h41, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{5'd0, 7'd1, 8'h00, 8'h00}},
    '{'{OP_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1, 1'b1, '{5'd0, 7'd2, 8'h00, 8'h00}},
    '{'{OP_PUT, 8'h00, 8'h5A, 5'd0, 7'd0}, 1, 1'b1, '{5'd0, 7'd3, 8'h00, 8'h00}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd0, 7'd1}, 1, 1'b1, '{5'd0, 7'd3, 8'hFF, 8'hFF}},
    '{'{OP_PUT, NEWLINE_CHAR, 8'h33, 5'd0, 7'd0}, 1, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00}},
    '{'{OP_PUT, NEWLINE_CHAR, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{5'd2, 7'd0, 8'h00, 8'h00}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd1, 7'd0}, 1, 1'b1,
      '{5'd2, 7'd0, BLANK_CHAR, RESET_ATTR}},
    '{'{OP_PUT, 8'h42, 8'h1E, 5'd0, 7'd0}, 80, 1'b0, '0},
    '{'{OP_READ, 8'h00, 8'h00, 5'd2, 7'd79}, 1, 1'b1, '{5'd3, 7'd0, 8'h42, 8'h1E}},
    '{'{OP_PUT, NEWLINE_CHAR, 8'h00, 5'd0, 7'd0}, 21, 1'b0, '0},
    '{'{OP_PUT, 8'h43, 8'h7C, 5'd0, 7'd0}, 79, 1'b0, '0},
    '{'{OP_PUT, 8'h44, 8'h7C, 5'd0, 7'd0}, 1, 1'b0, '0},
    '{'{OP_READ, 8'h00, 8'h00, 5'd23, 7'd79}, 1, 1'b0, '0},
    '{'{OP_READ, 8'h00, 8'h00, 5'd24, 7'd5}, 1, 1'b0, '0},
    '{'{OP_PUT, NEWLINE_CHAR, 8'hC3, 5'd0, 7'd0}, 2, 1'b0, '0},
    '{'{OP_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1, 1'b0, '0},
    '{'{OP_CLEAR, 8'h55, 8'hA5, 5'd0, 7'd0}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd12, 7'd40}, 1, 1'b1,
      '{5'd0, 7'd0, BLANK_CHAR, 8'hA5}},
    '{'{OP_CLEAR, 8'h00, 8'h00, 5'd0, 7'd0}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
    '{'{OP_READ, 8'h00, 8'h00, 5'd24, 7'd79}, 1, 1'b1,
      '{5'd0, 7'd0, BLANK_CHAR, 8'hFF}}
  };

  text_console_writer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_char_code   (in_char_code),
    .in_attribute   (in_attribute),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic void screen_fill(logic [7:0] attr);
    for (int i = 0; i < CELLS; i++) screen[i] = {attr, BLANK_CHAR};
    cur_row = 0;
    cur_col = 0;
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {fill_attr, BLANK_CHAR};
      cur_row = ROWS - 1;
      scrolls++;
    end
  endfunction

  function automatic view_t console_step(cmd_t c);
    view_t v;
    v = '0;
    case (c.op)
      OP_PUT: begin
        if (c.ch == NEWLINE_CHAR) begin
          line_feed();
        end else begin
          screen[cur_row * COLS + cur_col] = {c.attr, c.ch};
          cur_col++;
          if (cur_col >= COLS) line_feed();
        end
      end
      OP_CLEAR: begin
        screen_fill(c.attr);
        clears++;
      end
      OP_READ: begin
        if (c.rr < ROWS && c.rc < COLS) begin
          {v.cattr, v.cchar} = screen[c.rr * COLS + c.rc];
        end
      end
      default: ;
    endcase
    v.row = cur_row[4:0];
    v.col = cur_col[6:0];
    return v;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    pick   = $urandom_range(0, 199);
    c.op   = OP_PUT;
    c.ch   = 8'($urandom_range(0, 255));
    c.attr = 8'($urandom_range(0, 255));
    c.rr   = 5'($urandom_range(0, 31));
    c.rc   = 7'($urandom_range(0, 127));
    if (pick >= 128 && pick < 158) begin
      c.ch = NEWLINE_CHAR;
    end else if (pick >= 158 && pick < 192) begin
      c.op = OP_READ;
      if (pick < 186) begin
        c.rr = 5'($urandom_range(0, 1) ? cur_row : $urandom_range(0, ROWS - 1));
        c.rc = 7'($urandom_range(0, COLS - 1));
      end
    end else if (pick >= 192 && pick < 198) begin
      c.op = OP_NOP;
    end else if (pick >= 198) begin
      c.op = OP_CLEAR;
    end
    return c;
  endfunction

  task automatic offer(cmd_t c, bit typed, view_t want);
    view_t v;
    in_valid     <= 1'b1;
    in_opcode    <= c.op;
    in_char_code <= c.ch;
    in_attribute <= c.attr;
    in_read_row  <= c.rr;
    in_read_col  <= c.rc;
    do @(posedge clk); while (in_stall);
    v = console_step(c);
    due_results.push_back(typed ? want : v);
    items_sent++;
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      offer(random_cmd(), 1'b0, '0);
      idle_gap();
    end
  endtask

  // drain every result and leave the block idle before the next phase
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_fill_attr(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_IDX_FILL_ATTR);
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fill_attr = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = OP_NOP;
    in_char_code = 8'h00;
    in_attribute = 8'h00;
    in_read_row  = 5'd0;
    in_read_col  = 7'd0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = 32'h0;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    scrolls      = 0;
    clears       = 0;
    hold_req     = 1'b0;
    quiet        = 1'b0;
    fill_attr    = RESET_ATTR;
    screen_fill(RESET_ATTR);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        offer(dir_tab[r].cmd, dir_tab[r].typed, dir_tab[r].want);
        idle_gap();
      end
    end

    settle();
    write_fill_attr(8'h00);
    run_random(90);

    settle();
    write_fill_attr(8'hFF);
    hold_req = 1'b1;
    run_random(90);

    settle();
    write_fill_attr(8'($urandom_range(1, 254)));
    run_random(60);

    // no idling on either side from here on
    settle();
    write_fill_attr(8'($urandom_range(0, 255)));
    quiet = 1'b1;
    run_random(60);

    settle();
    $display("covered %0d items, %0d results, %0d scrolls and %0d clears",
             items_sent, results_seen, scrolls, clears);
    $display("fill attribute 0x0f, 0x00, 0xff and two random values; one %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    view_t got;
    view_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_cursor_row, out_cursor_col, out_cell_char, out_cell_attr};
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: row %0d col %0d char %02h attr %02h",
                 $time, got.row, got.col, got.cchar, got.cattr);
      end else begin
        want = due_results.pop_front();
        results_seen++;
        if (got != want) begin
          errors++;
          $display("%0t: expected %0d/%0d %02h/%02h, got %0d/%0d %02h/%02h",
                   $time, want.row, want.col, want.cchar, want.cattr,
                   got.row, got.col, got.cchar, got.cattr);
        end
      end
    end
  end

endmodule
